>>> rtl/core/asf_pkg.sv
// Package for the strength-of-connection filter: types, constants, helpers.
// Used by asf_ctrl, asf_datapath and the top level; depends on nothing.
`default_nettype none
package asf_pkg;
    localparam int MAX_ROW_ENTRIES = 32;
    localparam int INDEX_WIDTH     = 20;
    localparam int VALUE_WIDTH     = 32;
    localparam int MODE_WIDTH      = 2;
    localparam int EPS_WIDTH       = 17;
    localparam int RSL_WIDTH       = 18;
    localparam int CFG_WIDTH       = 18;
    localparam int CFG_IDX_WIDTH   = 2;
    localparam int SUM_WIDTH       = 38;
    localparam int MAG_WIDTH       = 33;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_EPS  = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_RSL  = 2'd2;

    localparam logic [MODE_WIDTH-1:0] MODE_MODIFIED = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_NEGATIVE = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_ABSOLUTE = 2'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_SPARE    = 2'd3;

    localparam logic [EPS_WIDTH-1:0] EPS_RESET = 17'd19661;
    localparam logic [RSL_WIDTH-1:0] RSL_RESET = 18'd58982;
    localparam logic [RSL_WIDTH-1:0] Q_ONE     = 18'd65536;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_TEST,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic test;
        logic decide;
        logic emit_start;
        logic emit_step;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic row_closed;
        logic scan_last;
        logic emit_last;
    } t_status;
endpackage
`default_nettype wire

>>> rtl/core/asf_ctrl.sv
// Controller state machine of the strength filter.
// Depends on asf_pkg; drives the datapath through t_cmd and reads t_status.
`default_nettype none
module asf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_fire,
    input  wire              i_out_free,
    input  asf_pkg::t_status i_status,
    output logic             o_in_ready,
    output asf_pkg::t_cmd    o_cmd
);
    asf_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= asf_pkg::ST_LOAD;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            asf_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_fire;
                if (i_in_fire && i_status.row_closed) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = asf_pkg::ST_SCAN;
                end
            end
            asf_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) n_state = asf_pkg::ST_TEST;
            end
            asf_pkg::ST_TEST: begin
                o_cmd.test = 1'b1;
                n_state = asf_pkg::ST_DECIDE;
            end
            asf_pkg::ST_DECIDE: begin
                o_cmd.decide     = 1'b1;
                o_cmd.emit_start = 1'b1;
                n_state = asf_pkg::ST_EMIT;
            end
            asf_pkg::ST_EMIT: begin
                if (i_out_free) begin
                    o_cmd.emit_step = 1'b1;
                    if (i_status.emit_last) begin
                        o_cmd.clear = 1'b1;
                        n_state = asf_pkg::ST_LOAD;
                    end
                end
            end
            default: n_state = asf_pkg::ST_LOAD;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/core/asf_datapath.sv
// Datapath of the strength filter: entry buffer, row statistics, classifier.
// Depends on asf_pkg; commanded by asf_ctrl.
`default_nettype none
module asf_datapath #(
    parameter int MAX_ROW_ENTRIES = asf_pkg::MAX_ROW_ENTRIES,
    parameter int INDEX_WIDTH     = asf_pkg::INDEX_WIDTH
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  asf_pkg::t_cmd                       i_cmd,
    input  wire [INDEX_WIDTH-1:0]               i_row,
    input  wire [INDEX_WIDTH-1:0]               i_col,
    input  wire signed [asf_pkg::VALUE_WIDTH-1:0] i_value,
    input  wire                                 i_row_end,
    input  wire [asf_pkg::MODE_WIDTH-1:0]       i_mode,
    input  wire [asf_pkg::EPS_WIDTH-1:0]        i_eps,
    input  wire [asf_pkg::RSL_WIDTH-1:0]        i_rsl,
    output asf_pkg::t_status                    o_status,
    output logic [INDEX_WIDTH-1:0]              o_row,
    output logic [INDEX_WIDTH-1:0]              o_col,
    output logic                                o_strong,
    output logic                                o_done,
    output logic                                o_overflow
);
    localparam int AW = $clog2(MAX_ROW_ENTRIES);
    localparam int CW = $clog2(MAX_ROW_ENTRIES + 1);
    localparam int VW = asf_pkg::VALUE_WIDTH;
    localparam int MW = asf_pkg::MAG_WIDTH;
    localparam int SW = asf_pkg::SUM_WIDTH;
    localparam logic [CW-1:0] DEPTH = CW'(MAX_ROW_ENTRIES);

    logic [INDEX_WIDTH-1:0] r_col_mem [MAX_ROW_ENTRIES];
    logic signed [VW-1:0]   r_val_mem [MAX_ROW_ENTRIES];
    logic [CW-1:0]          r_count;
    logic signed [VW-1:0]   r_min;
    logic signed [SW-1:0]   r_sum;
    logic signed [MW-1:0]   r_diag;
    logic                   r_have_diag;
    logic signed [MW-1:0]   r_peak;
    logic                   r_ovf;
    logic [INDEX_WIDTH-1:0] r_row;
    logic [CW-1:0]          r_ptr;
    logic [INDEX_WIDTH-1:0] r_rd_col;
    logic signed [VW-1:0]   r_rd_val;
    logic                   r_rd_ok;
    logic                   r_all_weak;
    logic signed [MW+17:0]  r_lhs;
    logic signed [MW+17:0]  r_rhs;
    logic [1:0]             r_md;

    logic [1:0]             w_md;
    logic                   w_room;
    logic                   w_diag_hit;
    logic signed [MW-1:0]   w_ext;
    logic signed [MW-1:0]   w_m;
    logic [SW-1:0]          w_abs_sum;
    logic [MW-1:0]          w_d;
    logic                   w_strong;
    logic [AW-1:0]          w_rd_addr;
    logic signed [VW-1:0]   w_v;
    logic signed [MW-1:0]   w_vx;
    logic signed [MW+17:0]  w_lhs;
    logic signed [MW+17:0]  w_rhs;

    assign w_md   = (i_mode == asf_pkg::MODE_SPARE) ? asf_pkg::MODE_ABSOLUTE : i_mode;
    assign w_room = r_count < DEPTH;
    assign w_ext  = MW'(r_rd_val);
    assign w_diag_hit = r_rd_ok && (r_rd_col == r_row);
    assign w_m = (r_md == asf_pkg::MODE_NEGATIVE) ? -w_ext
               : (w_ext < 0 ? -w_ext : w_ext);
    assign w_abs_sum = r_sum < 0 ? SW'(-r_sum) : SW'(r_sum);
    assign w_d = (r_diag == 0) ? MW'(1) : (r_diag < 0 ? MW'(-r_diag) : MW'(r_diag));

    // read address: during emit, the entry that r_ptr moves to; otherwise the entry at r_ptr
    assign w_rd_addr = i_cmd.emit_start ? '0
                     : i_cmd.emit_step ? r_ptr[AW-1:0] + AW'(1)
                     : r_ptr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_room) begin
            r_col_mem[r_count[AW-1:0]] <= i_col;
            r_val_mem[r_count[AW-1:0]] <= i_value;
        end
        r_rd_col <= r_col_mem[w_rd_addr];
        r_rd_val <= r_val_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count <= '0; r_min <= '0; r_sum <= '0; r_diag <= '0;
            r_have_diag <= 1'b0; r_peak <= '0; r_ovf <= 1'b0;
            r_ptr <= '0; r_rd_ok <= 1'b0; r_all_weak <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (w_room) begin
                    r_count <= r_count + CW'(1);
                    if (i_value < r_min) r_min <= i_value;
                    r_sum <= r_sum + SW'(i_value);
                end else begin
                    r_ovf <= 1'b1;
                end
                r_row <= i_row;
                r_md  <= w_md;
            end
            if (i_cmd.scan_start) r_ptr <= '0;
            if (i_cmd.scan_step) begin
                r_rd_ok <= r_ptr < r_count;
                if (r_ptr < r_count) r_ptr <= r_ptr + CW'(1);
                if (w_diag_hit && !r_have_diag) begin
                    r_diag <= w_ext;
                    r_have_diag <= 1'b1;
                end else if (r_rd_ok && !w_diag_hit && w_m > r_peak) begin
                    r_peak <= w_m;
                end
            end
            if (i_cmd.test) begin
                r_lhs <= $signed({2'b00, w_abs_sum[MW-1:0], 16'd0});
                r_rhs <= $signed((MW+18)'(i_rsl) * (MW+18)'(w_d));
            end
            if (i_cmd.decide) begin
                r_all_weak <= (r_md == asf_pkg::MODE_MODIFIED) && (i_rsl < asf_pkg::Q_ONE)
                    && (w_abs_sum[SW-1:MW] != '0 || r_lhs > r_rhs);
            end
            if (i_cmd.emit_start) r_ptr <= '0;
            if (i_cmd.emit_step) r_ptr <= r_ptr + CW'(1);
        end
    end

    // strong test on the currently addressed entry, from the registered read
    assign w_v  = r_rd_val;
    assign w_vx = MW'(w_v);
    always_comb begin
        if (r_md == asf_pkg::MODE_MODIFIED) begin
            w_lhs = $signed({{2{w_vx[MW-1]}}, w_vx, 16'd0});
            w_rhs = $signed({1'b0, i_eps}) * (MW+18)'(r_min);
            w_strong = w_lhs < w_rhs;
        end else begin
            if (r_md == asf_pkg::MODE_NEGATIVE)
                w_lhs = -($signed({{2{w_vx[MW-1]}}, w_vx, 16'd0}));
            else
                w_lhs = $signed({{2{1'b0}}, (w_vx < 0 ? -w_vx : w_vx), 16'd0});
            w_rhs = $signed({1'b0, i_eps}) * (MW+18)'(r_peak);
            w_strong = w_lhs >= w_rhs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_step) begin
            o_row      <= r_row;
            o_col      <= r_rd_col;
            o_strong   <= w_strong && !r_all_weak && (r_rd_col != r_row);
            o_done     <= (r_ptr + CW'(1) == r_count);
            o_overflow <= r_ovf;
        end
    end

    assign o_status.row_closed = i_row_end;
    assign o_status.scan_last  = r_rd_ok == 1'b0 && r_ptr == r_count && r_count != '0
                                 ? 1'b1 : (r_ptr == r_count && !r_rd_ok);
    assign o_status.emit_last  = (r_ptr + CW'(1) >= r_count);
endmodule
`default_nettype wire

>>> rtl/core/amg_strength_filter_top.sv
// Top level of the strength-of-connection filter.
// Depends on asf_pkg, asf_ctrl and asf_datapath.
// Takes one nonzero per cycle while a row loads; after the row-end item, a scan over the
// buffer, a test step and a decide step, then one result per cycle while the output is
// not held by m_axis_tready. Input is held off from the row end until the last result of
// the row has moved into the output register.
`default_nettype none
module amg_strength_filter_top #(
    parameter int MAX_ROW_ENTRIES = asf_pkg::MAX_ROW_ENTRIES,
    parameter int INDEX_WIDTH     = asf_pkg::INDEX_WIDTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    // row_number, column_number, entry_value, zero fill
    input  wire [((2*INDEX_WIDTH+32+7)/8)*8-1:0] s_axis_tdata,
    input  wire        s_axis_tlast,
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    // out_row, out_col, strong_res, row_overflow, zero fill
    output logic [((2*INDEX_WIDTH+2+7)/8)*8-1:0] m_axis_tdata,
    output logic       m_axis_tlast,
    input  wire        i_cfg_we,
    input  wire [asf_pkg::CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  wire [asf_pkg::CFG_WIDTH-1:0]     i_cfg_data
);
    localparam int OW = ((2*INDEX_WIDTH+2+7)/8)*8;
    logic [asf_pkg::MODE_WIDTH-1:0] r_mode;
    logic [asf_pkg::EPS_WIDTH-1:0]  r_eps;
    logic [asf_pkg::RSL_WIDTH-1:0]  r_rsl;
    logic r_valid;
    asf_pkg::t_cmd    w_cmd;
    asf_pkg::t_status w_status;
    logic w_fire, w_free;
    logic [INDEX_WIDTH-1:0] w_row, w_col;
    logic w_strong, w_done, w_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= asf_pkg::MODE_MODIFIED;
            r_eps  <= asf_pkg::EPS_RESET;
            r_rsl  <= asf_pkg::RSL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                asf_pkg::CFG_MODE: r_mode <= i_cfg_data[asf_pkg::MODE_WIDTH-1:0];
                asf_pkg::CFG_EPS:  r_eps  <= i_cfg_data[asf_pkg::EPS_WIDTH-1:0];
                asf_pkg::CFG_RSL:  r_rsl  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_fire = s_axis_tvalid && s_axis_tready;
    assign w_free = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)            r_valid <= 1'b0;
        else if (w_cmd.emit_step) r_valid <= 1'b1;
        else if (m_axis_tready)   r_valid <= 1'b0;
    end

    asf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_fire), .i_out_free(w_free),
        .i_status(w_status), .o_in_ready(s_axis_tready), .o_cmd(w_cmd)
    );

    asf_datapath #(.MAX_ROW_ENTRIES(MAX_ROW_ENTRIES), .INDEX_WIDTH(INDEX_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_row(s_axis_tdata[INDEX_WIDTH-1:0]),
        .i_col(s_axis_tdata[2*INDEX_WIDTH-1:INDEX_WIDTH]),
        .i_value(s_axis_tdata[2*INDEX_WIDTH+31:2*INDEX_WIDTH]),
        .i_row_end(s_axis_tlast), .i_mode(r_mode), .i_eps(r_eps), .i_rsl(r_rsl),
        .o_status(w_status), .o_row(w_row), .o_col(w_col), .o_strong(w_strong),
        .o_done(w_done), .o_overflow(w_ovf)
    );

    assign m_axis_tvalid = r_valid;
    assign m_axis_tlast  = w_done;
    assign m_axis_tdata  = OW'({w_ovf, w_strong, w_col, w_row});
endmodule
`default_nettype wire

>>> rtl/core/asf_checker.sv
// Port-level checker for the strength filter, bound to the top level.
// Depends on amg_strength_filter_top ports only.
`default_nettype none
module asf_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire s_axis_tready,
    input wire m_axis_tvalid,
    input wire m_axis_tready,
    input wire m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready) else $error("input during row");
    a_last_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))
        else $error("last changed while held");
endmodule

bind amg_strength_filter_top asf_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
